@@ sv/beta_after_energy_loss_defines.svh @@
// Assertion macros used by the top RTL file of the beta correction block.
`ifndef BETA_AFTER_ENERGY_LOSS_DEFINES_SVH
`define BETA_AFTER_ENERGY_LOSS_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define BAE_ASSERT_IMPL(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, checked outside reset.
`define BAE_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

@@ sv/bae_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none

package bae_pkg;

   localparam int BETA_W = 16;
   localparam int E_W    = 24;
   localparam int E1_W   = 25;

   // Nucleon mass 931.5 MeV in 1/256 MeV units, its double and its square.
   localparam int MASS_W = 18;
   localparam logic [MASS_W-1:0] MASS    = 18'd238464;
   localparam logic [MASS_W:0]   MASS2   = 19'd476928;
   localparam logic [35:0]       MASS_SQ = 36'(MASS) * 36'(MASS);

   // Energy quotient M^2 * 2^32 / (2^32 - beta^2) and its square root.
   localparam int D_W      = 2 * BETA_W + 1;
   localparam int Q1_W     = 51;
   localparam int G_W      = 26;
   localparam int DIV_PRE  = Q1_W - 2 * BETA_W;
   localparam logic [D_W-1:0] BETA_SQ_ONE = 33'h1_0000_0000;

   // Beta quotient E1*(E1+2M) * 2^32 / (E1+M)^2 and its square root.
   localparam int DEN_W = 50;
   localparam int Q2_W  = 2 * BETA_W;

   localparam logic [E_W-1:0] E_MAX = 24'hFF_FFFF;

   localparam logic signed [33:0] CORR_ROUND = 34'sd8192;
   localparam int CORR_SHIFT = 14;

   localparam int CSR_W      = 3;
   localparam int CSR_DATA_W = 24;
   localparam logic [CSR_W-1:0] CSR_BETA_SOURCE    = 3'd0;
   localparam logic [CSR_W-1:0] CSR_BETA_FIXED     = 3'd1;
   localparam logic [CSR_W-1:0] CSR_ENERGY_DEPOSIT = 3'd2;
   localparam logic [CSR_W-1:0] CSR_CORR_OFFSET    = 3'd3;
   localparam logic [CSR_W-1:0] CSR_CORR_GAIN      = 3'd4;
   localparam logic [CSR_W-1:0] CSR_CORR_MEAN      = 3'd5;

   localparam logic [1:0] SRC_MEASURED  = 2'd0;
   localparam logic [1:0] SRC_CORRECTED = 2'd1;
   localparam logic [1:0] SRC_FIXED     = 2'd2;
   // The spare source code behaves as the fixed source.
   localparam logic [1:0] SRC_SPARE     = 2'd3;

   localparam logic [1:0] ST_OK     = 2'd0;
   localparam logic [1:0] ST_RANGE  = 2'd1;
   localparam logic [1:0] ST_NOTPOS = 2'd2;

   localparam logic signed [15:0] GAIN_RESET = 16'sd16384;

   localparam int RSP_TDATA_W = 72;

   typedef struct packed {
      logic [1:0]        beta_source;
      logic [BETA_W-1:0] beta_fixed;
      logic [E_W-1:0]    energy_deposit;
      logic [BETA_W-1:0] corr_offset;
      logic signed [15:0] corr_gain;
      logic [BETA_W-1:0] corr_mean;
   } cfg_type;

   typedef struct packed {
      logic              valid;
      logic              oor;
      logic [BETA_W-1:0] beta;
   } beta_item_type;

   typedef struct packed {
      logic [1:0]            status;
      logic [E_W-1:0]        e0;
      logic signed [E1_W-1:0] e1;
   } tag_type;

   typedef struct packed {
      logic    valid;
      tag_type tag;
   } energy_item_type;

   typedef struct packed {
      logic                   valid;
      logic [1:0]             status;
      logic [BETA_W-1:0]      beta_out;
      logic [E_W-1:0]         e0;
      logic signed [E1_W-1:0] e1;
   } result_type;

endpackage

`default_nettype wire

@@ sv/bae_src.sv @@
`timescale 1ns / 1ps
`default_nettype none

module bae_src
   import bae_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              en,
   input  logic              in_valid,
   input  logic [BETA_W-1:0] in_beta,
   input  cfg_type           cfg,
   output beta_item_type     out_item
);

   logic               v1_ff;
   logic               v2_ff;
   logic [BETA_W-1:0]  mb1_ff;
   logic [BETA_W-1:0]  mb2_ff;
   logic signed [16:0] diff;
   logic signed [32:0] prod_in;
   logic signed [32:0] prod_ff;
   logic signed [33:0] rnd;
   logic signed [19:0] shf;
   logic signed [20:0] corr;
   logic               corr_oor;
   beta_item_type      item_in;
   beta_item_type      item_ff;

   assign diff    = $signed({1'b0, mb1_ff}) - $signed({1'b0, cfg.corr_mean});
   assign prod_in = 33'(cfg.corr_gain) * 33'(diff);

   // Arithmetic shift of the biased product floors, so ties round upward.
   assign rnd      = 34'(prod_ff) + CORR_ROUND;
   assign shf      = 20'(rnd >>> CORR_SHIFT);
   assign corr     = 21'(shf) + $signed({5'b0, cfg.corr_offset});
   assign corr_oor = corr[20:BETA_W] != 5'd0;

   always_comb begin
      item_in.valid = v2_ff;
      item_in.oor   = 1'b0;
      item_in.beta  = cfg.beta_fixed;
      case (cfg.beta_source)
         SRC_MEASURED: begin
            item_in.beta = mb2_ff;
         end
         SRC_CORRECTED: begin
            item_in.beta = corr[BETA_W-1:0];
            item_in.oor  = corr_oor;
         end
         default: begin
            item_in.beta = cfg.beta_fixed;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff   <= 1'b0;
         v2_ff   <= 1'b0;
         item_ff <= '0;
      end else if (en) begin
         v1_ff   <= in_valid;
         v2_ff   <= v1_ff;
         item_ff <= item_in;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         mb1_ff  <= in_beta;
         mb2_ff  <= mb1_ff;
         prod_ff <= prod_in;
      end
   end

   assign out_item = item_ff;

endmodule

`default_nettype wire

@@ sv/bae_energy.sv @@
`timescale 1ns / 1ps
`default_nettype none

module bae_energy
   import bae_pkg::*;
(
   input  logic            clock,
   input  logic            reset,
   input  logic            en,
   input  cfg_type         cfg,
   input  beta_item_type   in_item,
   output energy_item_type out_item
);

   // Restoring divider, one quotient bit per stage. Stage 0 holds the divisor.
   logic                 dv_ff [0:Q1_W];
   logic                 do_ff [0:Q1_W];
   logic [D_W-1:0]       dd_ff [0:Q1_W];
   logic [D_W-1:0]       dr_ff [0:Q1_W];
   logic [Q1_W-1:0]      dq_ff [0:Q1_W];

   // Digit-by-digit square root, one root bit per stage.
   logic                 sv_ff    [1:G_W];
   logic                 so_ff    [1:G_W];
   logic [2*G_W-1:0]     sx_ff    [1:G_W];
   logic [G_W+1:0]       srem_ff  [1:G_W];
   logic [G_W-1:0]       sroot_ff [1:G_W];

   logic [2*BETA_W-1:0]  bsq;
   logic [D_W-1:0]       d_in;
   logic [G_W-1:0]       g;
   logic [G_W-1:0]       gm;
   logic [E_W-1:0]       e0;
   logic signed [E1_W-1:0] e1;
   energy_item_type      item_in;
   energy_item_type      item_ff;

   assign bsq  = in_item.beta * in_item.beta;
   assign d_in = BETA_SQ_ONE - {1'b0, bsq};

   always_ff @(posedge clock) begin
      if (reset) begin
         dv_ff[0] <= 1'b0;
      end else if (en) begin
         dv_ff[0] <= in_item.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         do_ff[0] <= in_item.oor;
         dd_ff[0] <= d_in;
         dr_ff[0] <= D_W'(MASS_SQ >> DIV_PRE);
         dq_ff[0] <= '0;
      end
   end

   for (genvar k = 1; k <= Q1_W; k++) begin : g_div
      localparam int J = Q1_W - k;
      logic         nbit;
      logic [D_W:0] rs;
      logic         take;

      // The dividend is M^2 shifted up by 32 bits; its low bits are zero.
      if (J >= 2 * BETA_W) begin : g_hi
         assign nbit = MASS_SQ[J - 2 * BETA_W];
      end else begin : g_lo
         assign nbit = 1'b0;
      end

      assign rs   = {dr_ff[k-1], nbit};
      assign take = rs >= {1'b0, dd_ff[k-1]};

      always_ff @(posedge clock) begin
         if (reset) begin
            dv_ff[k] <= 1'b0;
         end else if (en) begin
            dv_ff[k] <= dv_ff[k-1];
         end
      end

      always_ff @(posedge clock) begin
         if (en) begin
            dr_ff[k] <= take ? D_W'(rs - {1'b0, dd_ff[k-1]}) : D_W'(rs);
            dq_ff[k] <= {dq_ff[k-1][Q1_W-2:0], take};
            dd_ff[k] <= dd_ff[k-1];
            do_ff[k] <= do_ff[k-1];
         end
      end
   end

   for (genvar s = 1; s <= G_W; s++) begin : g_sqrt
      localparam int P = 2 * (G_W - s);
      logic [2*G_W-1:0] px;
      logic [G_W+1:0]   prem;
      logic [G_W-1:0]   proot;
      logic             pv;
      logic             po;
      logic [G_W+1:0]   pre;
      logic [G_W+1:0]   trial;
      logic             take;

      if (s == 1) begin : g_first
         assign px    = (2*G_W)'(dq_ff[Q1_W]);
         assign prem  = '0;
         assign proot = '0;
         assign pv    = dv_ff[Q1_W];
         assign po    = do_ff[Q1_W];
      end else begin : g_next
         assign px    = sx_ff[s-1];
         assign prem  = srem_ff[s-1];
         assign proot = sroot_ff[s-1];
         assign pv    = sv_ff[s-1];
         assign po    = so_ff[s-1];
      end

      assign pre   = {prem[G_W-1:0], px[P+1:P]};
      assign trial = {proot, 2'b01};
      assign take  = pre >= trial;

      always_ff @(posedge clock) begin
         if (reset) begin
            sv_ff[s] <= 1'b0;
         end else if (en) begin
            sv_ff[s] <= pv;
         end
      end

      always_ff @(posedge clock) begin
         if (en) begin
            so_ff[s]    <= po;
            sx_ff[s]    <= px;
            srem_ff[s]  <= take ? pre - trial : pre;
            sroot_ff[s] <= {proot[G_W-2:0], take};
         end
      end
   end

   assign g  = sroot_ff[G_W];
   assign gm = g - G_W'(MASS);
   assign e0 = (g < G_W'(MASS)) ? '0 :
               ((gm[G_W-1:E_W] != '0) ? E_MAX : gm[E_W-1:0]);
   assign e1 = $signed({1'b0, e0}) - $signed({1'b0, cfg.energy_deposit});

   always_comb begin
      item_in.valid = sv_ff[G_W];
      if (so_ff[G_W]) begin
         item_in.tag.status = ST_RANGE;
         item_in.tag.e0     = '0;
         item_in.tag.e1     = '0;
      end else begin
         item_in.tag.status = (e1 <= 0) ? ST_NOTPOS : ST_OK;
         item_in.tag.e0     = e0;
         item_in.tag.e1     = e1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         item_ff <= '0;
      end else if (en) begin
         item_ff <= item_in;
      end
   end

   assign out_item = item_ff;

endmodule

`default_nettype wire

@@ sv/bae_beta.sv @@
`timescale 1ns / 1ps
`default_nettype none

module bae_beta
   import bae_pkg::*;
(
   input  logic            clock,
   input  logic            reset,
   input  logic            en,
   input  energy_item_type in_item,
   output result_type      out_item
);

   logic               pv_ff;
   tag_type            ptag_ff;
   logic [E_W-1:0]     pe_ff;
   logic [E_W+1:0]     ps_ff;
   logic [E_W:0]       pt_ff;
   logic [DEN_W-1:0]   n_in;
   logic [DEN_W-1:0]   den_in;

   // Stage 0 of the divider holds numerator and denominator.
   logic               bv_ff   [0:Q2_W];
   tag_type            btag_ff [0:Q2_W];
   logic [DEN_W-1:0]   bd_ff   [0:Q2_W];
   logic [DEN_W-1:0]   br_ff   [0:Q2_W];
   logic [Q2_W-1:0]    bq_ff   [0:Q2_W];

   logic               sv_ff    [1:BETA_W];
   tag_type            stag_ff  [1:BETA_W];
   logic [Q2_W-1:0]    sx_ff    [1:BETA_W];
   logic [BETA_W+1:0]  srem_ff  [1:BETA_W];
   logic [BETA_W-1:0]  sroot_ff [1:BETA_W];

   result_type         res_in;
   result_type         res_ff;

   assign n_in   = pe_ff * ps_ff;
   assign den_in = pt_ff * pt_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         pv_ff    <= 1'b0;
         bv_ff[0] <= 1'b0;
      end else if (en) begin
         pv_ff    <= in_item.valid;
         bv_ff[0] <= pv_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         ptag_ff    <= in_item.tag;
         pe_ff      <= in_item.tag.e1[E_W-1:0];
         ps_ff      <= (E_W+2)'(in_item.tag.e1[E_W-1:0]) + (E_W+2)'(MASS2);
         pt_ff      <= (E_W+1)'(in_item.tag.e1[E_W-1:0]) + (E_W+1)'(MASS);
         btag_ff[0] <= ptag_ff;
         br_ff[0]   <= n_in;
         bd_ff[0]   <= den_in;
         bq_ff[0]   <= '0;
      end
   end

   // The numerator is always below the denominator, so every quotient bit is a fraction bit.
   for (genvar k = 1; k <= Q2_W; k++) begin : g_div
      logic [DEN_W:0] rs;
      logic           take;

      assign rs   = {br_ff[k-1], 1'b0};
      assign take = rs >= {1'b0, bd_ff[k-1]};

      always_ff @(posedge clock) begin
         if (reset) begin
            bv_ff[k] <= 1'b0;
         end else if (en) begin
            bv_ff[k] <= bv_ff[k-1];
         end
      end

      always_ff @(posedge clock) begin
         if (en) begin
            br_ff[k]   <= take ? DEN_W'(rs - {1'b0, bd_ff[k-1]}) : DEN_W'(rs);
            bq_ff[k]   <= {bq_ff[k-1][Q2_W-2:0], take};
            bd_ff[k]   <= bd_ff[k-1];
            btag_ff[k] <= btag_ff[k-1];
         end
      end
   end

   for (genvar s = 1; s <= BETA_W; s++) begin : g_sqrt
      localparam int P = 2 * (BETA_W - s);
      logic [Q2_W-1:0]   px;
      logic [BETA_W+1:0] prem;
      logic [BETA_W-1:0] proot;
      logic              pv;
      tag_type           ptag;
      logic [BETA_W+1:0] pre;
      logic [BETA_W+1:0] trial;
      logic              take;

      if (s == 1) begin : g_first
         assign px    = bq_ff[Q2_W];
         assign prem  = '0;
         assign proot = '0;
         assign pv    = bv_ff[Q2_W];
         assign ptag  = btag_ff[Q2_W];
      end else begin : g_next
         assign px    = sx_ff[s-1];
         assign prem  = srem_ff[s-1];
         assign proot = sroot_ff[s-1];
         assign pv    = sv_ff[s-1];
         assign ptag  = stag_ff[s-1];
      end

      assign pre   = {prem[BETA_W-1:0], px[P+1:P]};
      assign trial = {proot, 2'b01};
      assign take  = pre >= trial;

      always_ff @(posedge clock) begin
         if (reset) begin
            sv_ff[s] <= 1'b0;
         end else if (en) begin
            sv_ff[s] <= pv;
         end
      end

      always_ff @(posedge clock) begin
         if (en) begin
            stag_ff[s]  <= ptag;
            sx_ff[s]    <= px;
            srem_ff[s]  <= take ? pre - trial : pre;
            sroot_ff[s] <= {proot[BETA_W-2:0], take};
         end
      end
   end

   always_comb begin
      res_in.valid    = sv_ff[BETA_W];
      res_in.status   = stag_ff[BETA_W].status;
      res_in.e0       = stag_ff[BETA_W].e0;
      res_in.e1       = stag_ff[BETA_W].e1;
      res_in.beta_out = (stag_ff[BETA_W].status == ST_OK) ? sroot_ff[BETA_W] : '0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         res_ff <= '0;
      end else if (en) begin
         res_ff <= res_in;
      end
   end

   assign out_item = res_ff;

endmodule

`default_nettype wire

@@ sv/beta_after_energy_loss.sv @@
// Accepts one item per cycle while the skid entry of the output buffer is empty.
// The pipeline holds the 51-stage energy divider, the 26-stage and 16-stage root
// units and the 32-stage beta divider, each retiring one bit per register stage.
// A two-entry output buffer keeps input transfers going while a result waits.
// Reset is synchronous: it empties the pipeline and output buffer and loads the
// register defaults; no memory needs clearing.
`timescale 1ns / 1ps
`default_nettype none

`include "beta_after_energy_loss_defines.svh"

module beta_after_energy_loss
   import bae_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_tvalid,
   output logic                   req_tready,
   input  logic [BETA_W-1:0]      req_tdata,  // measured_beta
   output logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   output logic [RSP_TDATA_W-1:0] rsp_tdata,  // beta_out, energy_before, energy_after
   output logic [1:0]             rsp_tuser,  // status
   input  logic                   csr_we,
   input  logic [CSR_W-1:0]       csr_addr,
   input  logic [CSR_DATA_W-1:0]  csr_wdata
);

   cfg_type         cfg_ff;
   logic            en;
   beta_item_type   src_item;
   energy_item_type eng_item;
   result_type      last;
   result_type      out_ff;
   result_type      out_in;
   result_type      skid_ff;
   result_type      skid_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.beta_source    <= SRC_MEASURED;
         cfg_ff.beta_fixed     <= '0;
         cfg_ff.energy_deposit <= '0;
         cfg_ff.corr_offset    <= '0;
         cfg_ff.corr_gain      <= GAIN_RESET;
         cfg_ff.corr_mean      <= '0;
      end else if (csr_we) begin
         case (csr_addr)
            CSR_BETA_SOURCE:    cfg_ff.beta_source    <= csr_wdata[1:0];
            CSR_BETA_FIXED:     cfg_ff.beta_fixed     <= csr_wdata[BETA_W-1:0];
            CSR_ENERGY_DEPOSIT: cfg_ff.energy_deposit <= csr_wdata[E_W-1:0];
            CSR_CORR_OFFSET:    cfg_ff.corr_offset    <= csr_wdata[BETA_W-1:0];
            CSR_CORR_GAIN:      cfg_ff.corr_gain      <= $signed(csr_wdata[15:0]);
            CSR_CORR_MEAN:      cfg_ff.corr_mean      <= csr_wdata[BETA_W-1:0];
            default: begin
            end
         endcase
      end
   end

   // The whole pipeline advances unless the skid entry is occupied.
   assign en         = !skid_ff.valid;
   assign req_tready = en;

   bae_src u_src (
      .clock    (clock),
      .reset    (reset),
      .en       (en),
      .in_valid (req_tvalid),
      .in_beta  (req_tdata),
      .cfg      (cfg_ff),
      .out_item (src_item)
   );

   bae_energy u_energy (
      .clock    (clock),
      .reset    (reset),
      .en       (en),
      .cfg      (cfg_ff),
      .in_item  (src_item),
      .out_item (eng_item)
   );

   bae_beta u_beta (
      .clock    (clock),
      .reset    (reset),
      .en       (en),
      .in_item  (eng_item),
      .out_item (last)
   );

   always_comb begin
      out_in  = out_ff;
      skid_in = skid_ff;
      if (skid_ff.valid) begin
         if (rsp_tready) begin
            out_in        = skid_ff;
            skid_in.valid = 1'b0;
         end
      end else if (!out_ff.valid || rsp_tready) begin
         out_in = last;
      end else if (last.valid) begin
         skid_in = last;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_ff  <= '0;
         skid_ff <= '0;
      end else begin
         out_ff  <= out_in;
         skid_ff <= skid_in;
      end
   end

   assign rsp_tvalid = out_ff.valid;
   assign rsp_tdata  = {7'b0, out_ff.e1, out_ff.e0, out_ff.beta_out};
   assign rsp_tuser  = out_ff.status;

   `BAE_ASSERT_IMPL(a_skid_needs_out, clock, reset, skid_ff.valid, out_ff.valid, "skid entry held while output register is empty")
   `BAE_ASSERT_NEXT(a_skid_drains, clock, reset, skid_ff.valid && rsp_tready, !skid_ff.valid && out_ff.valid, "skid entry not moved to output after transfer")
   `BAE_ASSERT_IMPL(a_range_zero, clock, reset, rsp_tvalid && rsp_tuser == ST_RANGE, rsp_tdata == '0, "out-of-range beta with nonzero fields")
   `BAE_ASSERT_IMPL(a_notpos_beta, clock, reset, rsp_tvalid && rsp_tuser == ST_NOTPOS, out_ff.beta_out == '0 && out_ff.e1 <= 0, "non-positive energy result inconsistent")
   `BAE_ASSERT_IMPL(a_ok_positive, clock, reset, rsp_tvalid && rsp_tuser == ST_OK, out_ff.e1 > 0, "good status with non-positive energy after target")

endmodule

`default_nettype wire
